FILE: hw/rtl/dop_pkg.sv
package dop_pkg;

    // Option codes of interest
    localparam logic [7:0] OPT_PAD        = 8'd0;
    localparam logic [7:0] OPT_SUBNET     = 8'd1;
    localparam logic [7:0] OPT_ROUTER     = 8'd3;
    localparam logic [7:0] OPT_DNS        = 8'd6;
    localparam logic [7:0] OPT_LEASE      = 8'd51;
    localparam logic [7:0] OPT_MSG_TYPE   = 8'd53;
    localparam logic [7:0] OPT_SERVER     = 8'd54;
    localparam logic [7:0] OPT_RENEW      = 8'd58;
    localparam logic [7:0] OPT_REBIND     = 8'd59;
    localparam logic [7:0] OPT_END        = 8'd255;

    // Captured word layout
    localparam int unsigned WORD_BYTES = 4;
    localparam int unsigned NUM_WORDS  = 7;

    localparam logic [2:0] SLOT_SUBNET = 3'd0;
    localparam logic [2:0] SLOT_ROUTER = 3'd1;
    localparam logic [2:0] SLOT_DNS    = 3'd2;
    localparam logic [2:0] SLOT_LEASE  = 3'd3;
    localparam logic [2:0] SLOT_RENEW  = 3'd4;
    localparam logic [2:0] SLOT_REBIND = 3'd5;
    localparam logic [2:0] SLOT_SERVER = 3'd6;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TRUNCATED = 2'd1,
        STATUS_OVERRUN   = 2'd2
    } status_t;

    typedef logic [NUM_WORDS-1:0][31:0] word_arr_t;

    typedef struct packed {
        logic        hit;
        logic        exact;
        logic [2:0]  idx;
    } slot_t;

    // Update of one captured word at the end of an option
    typedef struct packed {
        logic        valid;
        logic [2:0]  slot;
        logic [31:0] word;
    } commit_t;

    // Per-byte summary from the walker
    typedef struct packed {
        status_t     status;
        logic [7:0]  msg_type;
    } walk_res_t;

    // Map an option code to its captured word slot
    function automatic slot_t word_slot(input logic [7:0] code);
        slot_t s;
        s.hit   = 1'b1;
        s.exact = 1'b1;
        s.idx   = SLOT_SUBNET;
        unique case (code)
            OPT_SUBNET: s.idx = SLOT_SUBNET;
            OPT_ROUTER:
            begin
                s.idx   = SLOT_ROUTER;
                s.exact = 1'b0;
            end
            OPT_DNS:
            begin
                s.idx   = SLOT_DNS;
                s.exact = 1'b0;
            end
            OPT_LEASE:  s.idx = SLOT_LEASE;
            OPT_RENEW:  s.idx = SLOT_RENEW;
            OPT_REBIND: s.idx = SLOT_REBIND;
            OPT_SERVER: s.idx = SLOT_SERVER;
            default:    s.hit = 1'b0;
        endcase
        return s;
    endfunction

endpackage

FILE: hw/rtl/dop_in_if.sv
interface dop_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       clear_values;

    modport source (
        output valid, data_byte, first_byte, last_byte, clear_values,
        input  ready
    );
    modport sink (
        input  valid, data_byte, first_byte, last_byte, clear_values,
        output ready
    );
endinterface

FILE: hw/rtl/dop_out_if.sv
interface dop_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  parse_status;
    logic [7:0]  message_type;
    logic [31:0] subnet_mask;
    logic [31:0] router_addr;
    logic [31:0] dns_addr;
    logic [31:0] lease_seconds;
    logic [31:0] renew_seconds;
    logic [31:0] rebind_seconds;
    logic [31:0] server_addr;

    modport source (
        output valid, parse_status, message_type, subnet_mask, router_addr, dns_addr,
               lease_seconds, renew_seconds, rebind_seconds, server_addr,
        input  ready
    );
    modport sink (
        input  valid, parse_status, message_type, subnet_mask, router_addr, dns_addr,
               lease_seconds, renew_seconds, rebind_seconds, server_addr,
        output ready
    );
endinterface

FILE: hw/rtl/dop_walker.sv
module dop_walker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          data_byte,
    input  logic                first_byte,
    input  logic                last_byte,
    output dop_pkg::commit_t    commit,
    output dop_pkg::walk_res_t  res
);

    typedef enum logic [2:0] {
        PH_CODE = 3'd0,
        PH_LEN  = 3'd1,
        PH_DATA = 3'd2,
        PH_DONE = 3'd3,
        PH_IDLE = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  left_reg, left_next;
    logic [31:0] accum_reg, accum_next;
    logic [7:0]  msg_reg, msg_next;
    logic [7:0]  taken;
    logic        restart;
    dop_pkg::slot_t   slot;
    dop_pkg::status_t status;

    assign slot  = dop_pkg::word_slot(code_reg);
    assign taken = len_reg - left_reg;

    // Walk one byte through code, length and data
    always_comb
    begin
        code_next  = code_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        accum_next = accum_reg;
        msg_next   = msg_reg;
        commit     = '0;

        restart = first_byte || !(phase_reg == PH_CODE || phase_reg == PH_LEN ||
                                  phase_reg == PH_DATA || phase_reg == PH_DONE);
        phase_cur = restart ? PH_CODE : phase_reg;
        if (restart)
        begin
            msg_next = 8'd0;
        end
        phase_next = phase_cur;

        unique case (phase_cur)
            PH_CODE:
            begin
                if (data_byte == dop_pkg::OPT_END)
                begin
                    phase_next = PH_DONE;
                end
                else if (data_byte != dop_pkg::OPT_PAD)
                begin
                    code_next  = data_byte;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                len_next   = data_byte;
                left_next  = data_byte;
                accum_next = 32'd0;
                phase_next = (data_byte == 8'd0) ? PH_CODE : PH_DATA;
            end
            PH_DATA:
            begin
                if (taken < 8'(dop_pkg::WORD_BYTES))
                begin
                    accum_next = {accum_reg[23:0], data_byte};
                end
                left_next = left_reg - 8'd1;
                if (left_next == 8'd0)
                begin
                    phase_next = PH_CODE;
                    if (code_reg == dop_pkg::OPT_MSG_TYPE)
                    begin
                        if (len_reg == 8'd1)
                        begin
                            msg_next = accum_next[7:0];
                        end
                    end
                    else if (slot.hit)
                    begin
                        commit.valid = slot.exact ? (len_reg == 8'(dop_pkg::WORD_BYTES))
                                                  : (len_reg >= 8'(dop_pkg::WORD_BYTES));
                        commit.slot  = slot.idx;
                        commit.word  = accum_next;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Close the buffer and grade how it ended
        if (phase_next == PH_LEN)
        begin
            status = dop_pkg::STATUS_TRUNCATED;
        end
        else if (phase_next == PH_DATA)
        begin
            status = dop_pkg::STATUS_OVERRUN;
        end
        else
        begin
            status = dop_pkg::STATUS_OK;
        end
        if (last_byte)
        begin
            phase_next = PH_IDLE;
        end

        commit.valid = commit.valid && advance;
        res.status   = status;
        res.msg_type = msg_next;
    end

    // Hold parser state between words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CODE;
            code_reg  <= 8'd0;
            len_reg   <= 8'd0;
            left_reg  <= 8'd0;
            accum_reg <= 32'd0;
            msg_reg   <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            code_reg  <= code_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            accum_reg <= accum_next;
            msg_reg   <= msg_next;
        end
    end

endmodule

FILE: hw/rtl/dop_store.sv
module dop_store (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                clear_values,
    input  dop_pkg::commit_t    commit,
    output dop_pkg::word_arr_t  words_next
);

    dop_pkg::word_arr_t words_reg;

    // Clear first, then apply the option that just completed
    always_comb
    begin
        for (int i = 0; i < int'(dop_pkg::NUM_WORDS); i++)
        begin
            words_next[i] = clear_values ? 32'd0 : words_reg[i];
            if (commit.valid && commit.slot == 3'(i))
            begin
                words_next[i] = commit.word;
            end
        end
    end

    // Hold captured values across buffers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_reg <= '0;
        end
        else if (advance)
        begin
            words_reg <= words_next;
        end
    end

endmodule

FILE: hw/rtl/dhcp_option_parser_core.sv
// Streaming DHCP options parser, one byte word per cycle while the input is not stalled.
// The result is registered as the last byte is accepted and is shown in the cycle after.
// Throughput: one byte per cycle; input stalls only while a held result is not taken.
// Reset: asynchronous, active low; parser restarts at option code, all captured
// values and message type are zero, no result pending.
module dhcp_option_parser_core (
    input  logic      clk,
    input  logic      rst_n,
    dop_in_if.sink    options,
    dop_out_if.source report
);

    logic                advance;
    logic                rep_valid_reg;
    dop_pkg::commit_t    commit;
    dop_pkg::walk_res_t  res;
    dop_pkg::word_arr_t  words_next;
    dop_pkg::walk_res_t  res_reg;
    dop_pkg::word_arr_t  words_out_reg;

    assign options.ready = !rep_valid_reg || report.ready;
    assign advance       = options.valid && options.ready;

    dop_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .data_byte  (options.data_byte),
        .first_byte (options.first_byte),
        .last_byte  (options.last_byte),
        .commit     (commit),
        .res        (res)
    );

    dop_store u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .clear_values (options.clear_values),
        .commit       (commit),
        .words_next   (words_next)
    );

    // Track the pending result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_valid_reg <= 1'b0;
        end
        else if (advance && options.last_byte)
        begin
            rep_valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            rep_valid_reg <= 1'b0;
        end
    end

    // Capture the result on the last byte
    always_ff @(posedge clk)
    begin
        if (advance && options.last_byte)
        begin
            res_reg       <= res;
            words_out_reg <= words_next;
        end
    end

    assign report.valid          = rep_valid_reg;
    assign report.parse_status   = res_reg.status;
    assign report.message_type   = res_reg.msg_type;
    assign report.subnet_mask    = words_out_reg[dop_pkg::SLOT_SUBNET];
    assign report.router_addr    = words_out_reg[dop_pkg::SLOT_ROUTER];
    assign report.dns_addr       = words_out_reg[dop_pkg::SLOT_DNS];
    assign report.lease_seconds  = words_out_reg[dop_pkg::SLOT_LEASE];
    assign report.renew_seconds  = words_out_reg[dop_pkg::SLOT_RENEW];
    assign report.rebind_seconds = words_out_reg[dop_pkg::SLOT_REBIND];
    assign report.server_addr    = words_out_reg[dop_pkg::SLOT_SERVER];

endmodule
